// File: hw/rtl/phpm_pkg.sv
`timescale 1ns / 1ps
// shared constants and types for the piezo hit peak to midi block
// no dependencies; imported by every module of the block
package phpm_pkg;

    // fixed field widths
    localparam int CH_W        = 3;
    localparam int SMP_W       = 10;
    localparam int NOW_W       = 16;
    localparam int THR_W       = 10;
    localparam int NOTE_W      = 7;
    localparam int VEL_W       = 7;
    localparam int BYTE_W      = 8;
    localparam int IN_TDATA_W  = 32;

    // configuration registers
    localparam int THR_REG_W   = 60;
    localparam int NOTE_REG_W  = 42;
    localparam int WIN_W       = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 60;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLDS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NOTES      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW     = 2'd2;

    localparam logic [THR_REG_W-1:0]  THR_RESET  = 60'd33810090033182770;
    localparam logic [NOTE_REG_W-1:0] NOTE_RESET = 42'd2458486219851;
    localparam logic [WIN_W-1:0]      WIN_RESET  = 16'd50;

    // midi message bytes
    localparam logic [BYTE_W-1:0] NOTE_ON  = 8'h90;
    localparam logic [BYTE_W-1:0] NOTE_OFF = 8'h80;
    localparam logic [VEL_W-1:0]  VEL_MAX  = 7'd127;

    // byte positions within one hit message
    localparam int MSG_BYTES  = 6;
    localparam int BIDX_W     = 3;
    localparam logic [BIDX_W-1:0] B_ON    = 3'd0;
    localparam logic [BIDX_W-1:0] B_NOTE0 = 3'd1;
    localparam logic [BIDX_W-1:0] B_VEL0  = 3'd2;
    localparam logic [BIDX_W-1:0] B_OFF   = 3'd3;
    localparam logic [BIDX_W-1:0] B_NOTE1 = 3'd4;
    localparam logic [BIDX_W-1:0] B_VEL1  = 3'd5;

    // message queue
    localparam int MSG_DEPTH = 4;
    localparam int QPTR_W    = 2;
    localparam int QCNT_W    = 3;

    // parameter defaults
    localparam int CHANNELS_DEF    = 6;
    localparam int SAMPLE_BITS_DEF = 10;
    localparam int TIME_BITS_DEF   = 16;

    typedef struct packed {
        logic [NOTE_W-1:0] note;
        logic [VEL_W-1:0]  vel;
    } t_msg;

    typedef struct packed {
        logic valid;
        t_msg msg;
    } t_fire;

endpackage

// File: hw/rtl/phpm_chan_state.sv
`timescale 1ns / 1ps
// per-channel hit state: synchronous state memory with read-modify-write
// depends on phpm_pkg
module phpm_chan_state import phpm_pkg::*; #(
    parameter int CHANNELS    = CHANNELS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int TIME_BITS   = TIME_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  logic [CH_W-1:0]       i_channel,
    input  logic [SMP_W-1:0]      i_sample,
    input  logic [NOW_W-1:0]      i_now_ms,
    input  logic [THR_REG_W-1:0]  i_thresholds,
    input  logic [NOTE_REG_W-1:0] i_notes,
    input  logic [WIN_W-1:0]      i_window,
    output t_fire                 o_fire,
    output logic                  o_busy
);

    localparam int AW        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CW        = (TIME_BITS > WIN_W) ? TIME_BITS : WIN_W;
    localparam int OFF_START = 0;
    localparam int OFF_FIRED = TIME_BITS;
    localparam int OFF_ACT   = TIME_BITS + 1;
    localparam int OFF_PK    = TIME_BITS + 2;
    localparam int OFF_PS    = OFF_PK + SAMPLE_BITS;
    localparam int ST_W      = OFF_PS + SAMPLE_BITS;

    logic [ST_W-1:0] r_mem [CHANNELS];
    logic [CHANNELS-1:0] r_vld;

    logic                   r_s1_valid;
    logic                   r_s1_hit;
    logic [AW-1:0]          r_s1_addr;
    logic [SAMPLE_BITS-1:0] r_s1_smp;
    logic [TIME_BITS-1:0]   r_s1_now;
    logic [ST_W-1:0]        r_rd_data;
    logic                   r_rd_vld;
    logic                   r_fwd_sel;
    logic [ST_W-1:0]        r_fwd_data;

    logic                   in_range;
    logic [AW-1:0]          rd_addr;
    logic [ST_W-1:0]        cur;
    logic [ST_W-1:0]        n_state;
    logic [TIME_BITS-1:0]   cur_start;
    logic                   cur_fired;
    logic                   cur_act;
    logic [SAMPLE_BITS-1:0] cur_pk;
    logic [SAMPLE_BITS-1:0] cur_ps;
    logic [TIME_BITS-1:0]   elapsed;
    logic [THR_W-1:0]       thr_arr [CHANNELS];
    logic [NOTE_W-1:0]      note_arr [CHANNELS];
    logic [THR_W-1:0]       thr_sel;
    logic                   above;
    logic                   late;
    logic                   we;
    logic                   fire;

    assign in_range = i_channel < CH_W'(CHANNELS);
    assign rd_addr  = i_channel[AW-1:0];
    assign o_busy   = r_s1_valid;

    always_comb begin
        for (int c = 0; c < CHANNELS; c++) begin
            thr_arr[c]  = i_thresholds[c*THR_W +: THR_W];
            note_arr[c] = i_notes[c*NOTE_W +: NOTE_W];
        end
    end

    // newest copy of the entry: the write of the previous beat wins over the memory
    assign cur       = r_fwd_sel ? r_fwd_data : (r_rd_vld ? r_rd_data : '0);
    assign cur_start = cur[OFF_START +: TIME_BITS];
    assign cur_fired = cur[OFF_FIRED];
    assign cur_act   = cur[OFF_ACT];
    assign cur_pk    = cur[OFF_PK +: SAMPLE_BITS];
    assign cur_ps    = cur[OFF_PS +: SAMPLE_BITS];
    assign thr_sel   = thr_arr[r_s1_addr];
    assign above     = THR_W'(r_s1_smp) > thr_sel;
    assign elapsed   = r_s1_now - cur_start;
    assign late      = CW'(elapsed) >= CW'(i_window);
    assign we        = r_s1_valid && r_s1_hit && above;

    always_comb begin
        n_state = cur;
        fire    = 1'b0;
        if (!cur_act) begin
            n_state[OFF_ACT]                  = 1'b1;
            n_state[OFF_FIRED]                = 1'b0;
            n_state[OFF_START +: TIME_BITS]   = r_s1_now;
            n_state[OFF_PS +: SAMPLE_BITS]    = r_s1_smp;
        end else if (late) begin
            n_state[OFF_ACT]                  = 1'b0;
            n_state[OFF_FIRED]                = 1'b0;
            n_state[OFF_PK +: SAMPLE_BITS]    = '0;
            n_state[OFF_PS +: SAMPLE_BITS]    = '0;
        end else begin
            if (r_s1_smp < cur_ps) begin
                // falling edge: previous sample is a peak
                if (cur_ps < cur_pk && !cur_fired) begin
                    n_state[OFF_FIRED] = 1'b1;
                    fire               = 1'b1;
                end
                n_state[OFF_PK +: SAMPLE_BITS] = cur_ps;
            end
            n_state[OFF_PS +: SAMPLE_BITS] = r_s1_smp;
        end
    end

    always_comb begin
        o_fire.valid    = we && fire;
        o_fire.msg.note = note_arr[r_s1_addr];
        if (cur_pk > SAMPLE_BITS'(VEL_MAX)) begin
            o_fire.msg.vel = VEL_MAX;
        end else begin
            o_fire.msg.vel = cur_pk[VEL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[r_s1_addr] <= n_state;
        end
        if (i_accept && in_range) begin
            r_rd_data <= r_mem[rd_addr];
        end
        if (i_accept) begin
            r_s1_addr  <= rd_addr;
            r_s1_smp   <= i_sample[SAMPLE_BITS-1:0];
            r_s1_now   <= TIME_BITS'(i_now_ms);
            r_fwd_data <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld      <= '0;
            r_s1_valid <= 1'b0;
            r_s1_hit   <= 1'b0;
            r_rd_vld   <= 1'b0;
            r_fwd_sel  <= 1'b0;
        end else begin
            if (we) begin
                r_vld[r_s1_addr] <= 1'b1;
            end
            r_s1_valid <= i_accept;
            if (i_accept) begin
                r_s1_hit  <= in_range;
                r_rd_vld  <= in_range && r_vld[rd_addr];
                r_fwd_sel <= we && (i_channel == CH_W'(r_s1_addr));
            end
        end
    end

endmodule

// File: hw/rtl/phpm_msg_queue.sv
`timescale 1ns / 1ps
// queue of pending hit messages and the byte serializer with output register
// depends on phpm_pkg
module phpm_msg_queue import phpm_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_fire             i_fire,
    input  logic              i_inflight,
    output logic              o_space,
    output logic              o_tvalid,
    input  logic              i_tready,
    output logic [BYTE_W-1:0] o_tdata,
    output logic              o_tlast
);

    t_msg               r_q [MSG_DEPTH];
    logic [QPTR_W-1:0]  r_wp;
    logic [QPTR_W-1:0]  r_rp;
    logic [QCNT_W-1:0]  r_cnt;
    logic [BIDX_W-1:0]  r_bidx;
    logic               r_tvalid;
    logic [BYTE_W-1:0]  r_tdata;
    logic               r_tlast;

    logic               out_free;
    logic               emit;
    logic               pop;
    t_msg               head;
    logic [BYTE_W-1:0]  n_byte;

    // one slot held back for the beat in the state stage that may still fire
    assign o_space  = (r_cnt + QCNT_W'(i_inflight)) < QCNT_W'(MSG_DEPTH);
    assign out_free = !r_tvalid || i_tready;
    assign emit     = out_free && (r_cnt != '0);
    assign pop      = emit && (r_bidx == B_VEL1);
    assign head     = r_q[r_rp];

    assign o_tvalid = r_tvalid;
    assign o_tdata  = r_tdata;
    assign o_tlast  = r_tlast;

    always_comb begin
        case (r_bidx)
            B_ON:    n_byte = NOTE_ON;
            B_NOTE0: n_byte = {1'b0, head.note};
            B_VEL0:  n_byte = {1'b0, head.vel};
            B_OFF:   n_byte = NOTE_OFF;
            B_NOTE1: n_byte = {1'b0, head.note};
            B_VEL1:  n_byte = {1'b0, head.vel};
            default: n_byte = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_fire.valid) begin
            r_q[r_wp] <= i_fire.msg;
        end
        if (emit) begin
            r_tdata <= n_byte;
            r_tlast <= (r_bidx == B_VEL1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp     <= '0;
            r_rp     <= '0;
            r_cnt    <= '0;
            r_bidx   <= '0;
            r_tvalid <= 1'b0;
        end else begin
            if (i_fire.valid) begin
                r_wp <= r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + QCNT_W'(i_fire.valid) - QCNT_W'(pop);
            if (emit) begin
                r_bidx <= pop ? B_ON : r_bidx + 1'b1;
            end
            if (out_free) begin
                r_tvalid <= emit;
            end
        end
    end

endmodule

// File: hw/rtl/piezo_hit_peak_to_midi.sv
`timescale 1ns / 1ps
// top level of the piezo hit peak detector: configuration registers and glue
// depends on phpm_pkg, phpm_chan_state and phpm_msg_queue
//
// usage:
//   sample stream (i_s_*): one beat per converter sample, carrying channel,
//   sample and millisecond time. a new beat can be taken every cycle while the
//   queue has space; the per-channel state is read from a small synchronous
//   memory at acceptance and written back in the following cycle, with the
//   written entry forwarded when the next beat hits the same channel.
//   midi stream (o_m_*): a hit that fires gives six byte beats (note-on,
//   note, velocity, note-off, note, velocity), tlast on the sixth. the first
//   byte passes from the state stage through the queue to the output register,
//   and bytes then leave at one per cycle while the receiver takes them.
//   configuration (i_cfg_*): index 0 thresholds, 1 notes, 2 read window.
//   always ready; write only while the block is idle.
//   a queue of four pending messages sits before the output register, one slot
//   kept free while a beat is in the state stage; when the receiver stalls the
//   queue fills and s_tready drops for every sample until a message has left.
//   reset (synchronous, active low) clears every channel state through
//   per-entry valid bits and loads the default registers.
module piezo_hit_peak_to_midi import phpm_pkg::*; #(
    parameter int CHANNELS    = CHANNELS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int TIME_BITS   = TIME_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [IN_TDATA_W-1:0] i_s_tdata,   // channel[2:0], sample[12:3], now_ms[28:13]
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [BYTE_W-1:0]     o_m_tdata,   // midi_byte[7:0]
    output logic                  o_m_tlast,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [THR_REG_W-1:0]  r_thr;
    logic [NOTE_REG_W-1:0] r_notes;
    logic [WIN_W-1:0]      r_win;

    logic  accept;
    logic  space;
    logic  busy;
    t_fire fire;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = space;
    assign accept      = i_s_tvalid && space;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr   <= THR_RESET;
            r_notes <= NOTE_RESET;
            r_win   <= WIN_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_THRESHOLDS: r_thr   <= i_cfg_data[THR_REG_W-1:0];
                CFG_NOTES:      r_notes <= i_cfg_data[NOTE_REG_W-1:0];
                CFG_WINDOW:     r_win   <= i_cfg_data[WIN_W-1:0];
                default: ;
            endcase
        end
    end

    phpm_chan_state #(
        .CHANNELS    (CHANNELS),
        .SAMPLE_BITS (SAMPLE_BITS),
        .TIME_BITS   (TIME_BITS)
    ) u_state (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_channel    (i_s_tdata[CH_W-1:0]),
        .i_sample     (i_s_tdata[CH_W +: SMP_W]),
        .i_now_ms     (i_s_tdata[CH_W+SMP_W +: NOW_W]),
        .i_thresholds (r_thr),
        .i_notes      (r_notes),
        .i_window     (r_win),
        .o_fire       (fire),
        .o_busy       (busy)
    );

    phpm_msg_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (fire),
        .i_inflight (busy),
        .o_space    (space),
        .o_tvalid   (o_m_tvalid),
        .i_tready   (i_m_tready),
        .o_tdata    (o_m_tdata),
        .o_tlast    (o_m_tlast)
    );

endmodule
